/* design/lbg_pkg.sv */
// Shared types, constants and helper functions of the LED bar gauge renderer.
`timescale 1ns / 1ps
`default_nettype none
package lbg_pkg;

    localparam int MAX_LEDS    = 64;
    localparam int LED_W       = $clog2(MAX_LEDS);
    localparam int CNT_W       = LED_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS   = 16;
    localparam int DCNT_W      = $clog2(DIV_STEPS) + 1;

    localparam logic [16:0] HUE_0667 = 17'd43713;
    localparam logic [16:0] HUE_0333 = 17'd21823;
    localparam logic [16:0] HUE_1000 = 17'd65536;
    localparam logic [16:0] HUE_0000 = 17'd0;
    localparam logic [16:0] Q16_ONE  = 17'd65536;

    localparam logic [1:0] MODE_ALL   = 2'd0;
    localparam logic [1:0] MODE_TEMP  = 2'd1;
    localparam logic [1:0] MODE_PRESS = 2'd2;
    localparam logic [1:0] MODE_HUM   = 2'd3;

    localparam logic [1:0] QTY_TEMP  = 2'd0;
    localparam logic [1:0] QTY_PRESS = 2'd1;
    localparam logic [1:0] QTY_HUM   = 2'd2;

    typedef enum logic [2:0] {
        REG_LED_COUNT  = 3'd0,
        REG_TEMP_LOW   = 3'd1,
        REG_TEMP_SPAN  = 3'd2,
        REG_PRESS_LOW  = 3'd3,
        REG_PRESS_SPAN = 3'd4,
        REG_HUM_LOW    = 3'd5,
        REG_HUM_SPAN   = 3'd6
    } lbg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0]   led_count;
        logic signed [14:0] temp_low;
        logic [13:0]        temp_span;
        logic [16:0]        press_low;
        logic [16:0]        press_span;
        logic [13:0]        hum_low;
        logic [13:0]        hum_span;
    } lbg_cfg_t;

    typedef struct packed {
        logic signed [14:0] temperature;
        logic [16:0]        pressure;
        logic [13:0]        humidity;
        logic [1:0]         mode;
    } lbg_item_t;

    typedef struct packed {
        logic        start;
        logic [16:0] rem_init;
        logic [15:0] dividend;
        logic [16:0] divisor;
    } lbg_div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
        logic [16:0] rem;
    } lbg_div_rsp_t;

    // floor(x / 3) for x <= 128
    function automatic logic [6:0] div3(input logic [7:0] x);
        logic [15:0] prod;
        prod = x * 8'd171;
        return prod[15:9];
    endfunction

    function automatic logic [16:0] hue_start(input logic [1:0] qty);
        logic [16:0] h;
        case (qty)
            QTY_TEMP: h = HUE_0667;
            QTY_PRESS: h = HUE_0333;
            default: h = HUE_0333;
        endcase
        return h;
    endfunction

    function automatic logic [16:0] hue_stop(input logic [1:0] qty);
        logic [16:0] h;
        case (qty)
            QTY_TEMP: h = HUE_1000;
            QTY_PRESS: h = HUE_0000;
            default: h = HUE_0667;
        endcase
        return h;
    endfunction

    // magnitude of the hue sweep across a section
    function automatic logic [15:0] hue_delta(input logic [1:0] qty);
        logic [16:0] d;
        if (hue_stop(qty) >= hue_start(qty))
        begin
            d = hue_stop(qty) - hue_start(qty);
        end
        else
        begin
            d = hue_start(qty) - hue_stop(qty);
        end
        return d[15:0];
    endfunction

    function automatic logic hue_down(input logic [1:0] qty);
        return hue_stop(qty) < hue_start(qty);
    endfunction

endpackage
`default_nettype wire

/* design/lbg_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lbg_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lbg_pkg::lbg_div_req_t req,
    output lbg_pkg::lbg_div_rsp_t      rsp
);
    import lbg_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0]       rem_reg, rem_next;
    logic [15:0]       dvd_reg, dvd_next;
    logic [15:0]       quo_reg, quo_next;
    logic [16:0]       dsr_reg, dsr_next;
    logic [18:0]       diff;

    always_comb
    begin
        diff      = {1'b0, rem_reg, dvd_reg[15]} - {2'b00, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_STEPS);
            rem_next  = req.rem_init;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[14:0], 1'b0};
            if (!diff[18])
            begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[15:0], dvd_reg[15]};
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

/* design/lbg_queue.sv */
// Short FIFO of readings between the front and the renderer.
`timescale 1ns / 1ps
`default_nettype none
module lbg_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lbg_pkg::lbg_item_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output lbg_pkg::lbg_item_t      pop_data,
    output logic                    empty
);
    import lbg_pkg::*;

    lbg_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* design/lbg_front.sv */
// Input side: takes readings, keeps the display mode, queues readings to render.
`timescale 1ns / 1ps
`default_nettype none
module lbg_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [47:0]                 s_tdata,
    input  wire logic                        s_tuser,
    input  wire logic [lbg_pkg::CNT_W-1:0]   led_count,
    input  wire logic                        q_full,
    output logic                             push,
    output lbg_pkg::lbg_item_t               push_data
);
    import lbg_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic       accept;
    logic       next_pressed, previous_pressed;

    assign s_tready         = !q_full;
    assign accept           = s_tvalid && s_tready;
    assign next_pressed     = s_tdata[46];
    assign previous_pressed = s_tdata[47];

    assign push                  = accept && s_tuser && (led_count != '0);
    assign push_data.temperature = s_tdata[14:0];
    assign push_data.pressure    = s_tdata[31:15];
    assign push_data.humidity    = s_tdata[45:32];
    assign push_data.mode        = mode_reg;

    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            if (next_pressed)
            begin
                mode_next = mode_reg + 2'd1;
            end
            else if (previous_pressed)
            begin
                mode_next = mode_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ALL;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

endmodule
`default_nettype wire

/* design/lbg_back.sv */
// Renderer: per section works out fill level and hue step, then emits one beat per LED.
`timescale 1ns / 1ps
`default_nettype none
module lbg_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lbg_pkg::lbg_cfg_t     cfg,
    input  wire logic                  q_empty,
    input  wire lbg_pkg::lbg_item_t    q_data,
    output logic                       pop,
    output lbg_pkg::lbg_div_req_t      div_req,
    input  wire lbg_pkg::lbg_div_rsp_t div_rsp,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,  // led_index, hue, saturation_on, brightness
    output logic [1:0]                 m_tuser,  // shown_mode
    output logic                       m_tlast
);
    import lbg_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SEC   = 8'b0000_0010,
        S_PCT   = 8'b0000_0100,
        S_PWAIT = 8'b0000_1000,
        S_HDIV  = 8'b0001_0000,
        S_HWAIT = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    lbg_item_t         item_reg, item_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  a_reg, a_next;
    logic [CNT_W-1:0]  b_reg, b_next;
    logic [1:0]        sec_reg, sec_next;
    logic [1:0]        qty_reg, qty_next;
    logic              last_reg, last_next;
    logic [LED_W-1:0]  start_reg, start_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [16:0]       p_reg, p_next;
    logic [22:0]       l_reg, l_next;
    logic [15:0]       qstep_reg, qstep_next;
    logic [LED_W-1:0]  rstep_reg, rstep_next;
    logic [15:0]       accq_reg, accq_next;
    logic [LED_W-1:0]  accr_reg, accr_next;
    logic [LED_W-1:0]  i_reg, i_next;

    logic              out_valid_reg, out_valid_next;
    logic [LED_W-1:0]  idx_reg;
    logic [16:0]       hue_reg;
    logic              sat_reg;
    logic [16:0]       bri_reg;
    logic [1:0]        shown_reg;
    logic              olast_reg;

    logic [CNT_W-1:0]  sec_start, sec_end;
    logic [1:0]        sec_qty;
    logic              sec_last;
    logic [CNT_W-1:0]  n_sat;
    logic signed [17:0] num;
    logic [16:0]       span_eff;
    logic              num_le0, num_ge_span;
    logic [CNT_W-1:0]  rm1;
    logic              out_load;
    logic [CNT_W-1:0]  r_sum;
    logic [22:0]       lo, hi;
    logic              led_full, led_edge;
    logic [16:0]       hue_val;
    logic [16:0]       bri_val;

    // section bounds for the current item and section counter
    always_comb
    begin
        sec_start = '0;
        sec_end   = n_reg;
        sec_last  = 1'b1;
        sec_qty   = item_reg.mode - 2'd1;
        if (item_reg.mode == MODE_ALL)
        begin
            case (sec_reg)
                2'd0:
                begin
                    sec_qty  = QTY_TEMP;
                    sec_end  = a_reg;
                    sec_last = 1'b0;
                end
                2'd1:
                begin
                    sec_qty   = QTY_PRESS;
                    sec_start = a_reg;
                    sec_end   = b_reg;
                    sec_last  = 1'b0;
                end
                default:
                begin
                    sec_qty   = QTY_HUM;
                    sec_start = b_reg;
                end
            endcase
        end
    end

    // numerator and span of the percent for the selected quantity
    always_comb
    begin
        case (qty_reg)
            QTY_TEMP:
            begin
                num      = {{3{item_reg.temperature[14]}}, item_reg.temperature}
                         - {{3{cfg.temp_low[14]}}, cfg.temp_low};
                span_eff = {3'b000, cfg.temp_span};
            end
            QTY_PRESS:
            begin
                num      = {1'b0, item_reg.pressure} - {1'b0, cfg.press_low};
                span_eff = cfg.press_span;
            end
            default:
            begin
                num      = {4'b0000, item_reg.humidity} - {4'b0000, cfg.hum_low};
                span_eff = {3'b000, cfg.hum_span};
            end
        endcase
        if (span_eff == '0)
        begin
            span_eff = 17'd1;
        end
        num_le0     = num[17] || (num == '0);
        num_ge_span = !num[17] && (num[16:0] >= span_eff);
    end

    assign n_sat = (cfg.led_count > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : cfg.led_count;
    assign rm1   = r_reg - 1'b1;

    // per-LED values
    assign lo       = {1'b0, i_reg, 16'h0000};
    assign hi       = {i_reg + 7'd1, 16'h0000};
    assign led_full = (hi <= l_reg);
    assign led_edge = (lo <= l_reg);
    assign hue_val  = hue_down(qty_reg) ? (hue_start(qty_reg) - {1'b0, accq_reg})
                                        : (hue_start(qty_reg) + {1'b0, accq_reg});
    assign bri_val  = led_full ? Q16_ONE : 17'(l_reg - lo);
    assign r_sum    = {1'b0, accr_reg} + {1'b0, rstep_reg};

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);
    assign pop      = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.rem_init = num[16:0];
        div_req.dividend = '0;
        div_req.divisor  = span_eff;
        if (state_reg == S_PCT)
        begin
            div_req.start = !num_le0 && !num_ge_span;
        end
        else if (state_reg == S_HDIV)
        begin
            div_req.start    = (r_reg > CNT_W'(1));
            div_req.rem_init = '0;
            div_req.dividend = hue_delta(qty_reg);
            div_req.divisor  = {{(17-CNT_W){1'b0}}, rm1};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        n_next     = n_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sec_next   = sec_reg;
        qty_next   = qty_reg;
        last_next  = last_reg;
        start_next = start_reg;
        r_next     = r_reg;
        p_next     = p_reg;
        l_next     = l_reg;
        qstep_next = qstep_reg;
        rstep_next = rstep_reg;
        accq_next  = accq_reg;
        accr_next  = accr_reg;
        i_next     = i_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    item_next  = q_data;
                    n_next     = n_sat;
                    a_next     = div3({1'b0, n_sat});
                    b_next     = div3({n_sat, 1'b0});
                    sec_next   = '0;
                    state_next = S_SEC;
                end
            end
            S_SEC:
            begin
                if (sec_end > sec_start)
                begin
                    qty_next   = sec_qty;
                    last_next  = sec_last;
                    start_next = sec_start[LED_W-1:0];
                    r_next     = sec_end - sec_start;
                    state_next = S_PCT;
                end
                else if (sec_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sec_next = sec_reg + 2'd1;
                end
            end
            S_PCT:
            begin
                if (num_le0)
                begin
                    p_next     = '0;
                    state_next = S_HDIV;
                end
                else if (num_ge_span)
                begin
                    p_next     = Q16_ONE;
                    state_next = S_HDIV;
                end
                else
                begin
                    state_next = S_PWAIT;
                end
            end
            S_PWAIT:
            begin
                if (div_rsp.done)
                begin
                    p_next     = {1'b0, div_rsp.quo};
                    state_next = S_HDIV;
                end
            end
            S_HDIV:
            begin
                if (r_reg > CNT_W'(1))
                begin
                    state_next = S_HWAIT;
                end
                else
                begin
                    qstep_next = '0;
                    rstep_next = '0;
                    state_next = S_MUL;
                end
            end
            S_HWAIT:
            begin
                if (div_rsp.done)
                begin
                    qstep_next = div_rsp.quo;
                    rstep_next = div_rsp.rem[LED_W-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                l_next     = 23'(p_reg * r_reg);
                accq_next  = '0;
                accr_next  = '0;
                i_next     = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    if (r_sum >= rm1)
                    begin
                        accr_next = LED_W'(r_sum - rm1);
                        accq_next = accq_reg + qstep_reg + 16'd1;
                    end
                    else
                    begin
                        accr_next = r_sum[LED_W-1:0];
                        accq_next = accq_reg + qstep_reg;
                    end
                    i_next = i_reg + 1'b1;
                    if ({1'b0, i_reg} == rm1)
                    begin
                        if (last_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            sec_next   = sec_reg + 2'd1;
                            state_next = S_SEC;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        n_reg     <= n_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        qty_reg   <= qty_next;
        last_reg  <= last_next;
        start_reg <= start_next;
        r_reg     <= r_next;
        p_reg     <= p_next;
        l_reg     <= l_next;
        qstep_reg <= qstep_next;
        rstep_reg <= rstep_next;
        accq_reg  <= accq_next;
        accr_reg  <= accr_next;
        i_reg     <= i_next;
        if (out_load)
        begin
            idx_reg   <= start_reg + i_reg;
            hue_reg   <= led_edge ? hue_val : '0;
            sat_reg   <= led_edge;
            bri_reg   <= led_edge ? bri_val : '0;
            shown_reg <= item_reg.mode;
            olast_reg <= last_reg && ({1'b0, i_reg} == rm1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, bri_reg, sat_reg, hue_reg, idx_reg};
    assign m_tuser  = shown_reg;
    assign m_tlast  = olast_reg;

    a_emit_in_section: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ({1'b0, i_reg} < r_reg))
        else $error("LED counter beyond section length");

    a_bri_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (bri_reg <= Q16_ONE))
        else $error("brightness above full scale");

    a_off_led_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !sat_reg) |-> ((bri_reg == '0) && (hue_reg == '0)))
        else $error("unlit LED carries hue or brightness");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == S_PWAIT) || (state_reg == S_HWAIT)))
        else $error("divider result with no request pending");

endmodule
`default_nettype wire

/* design/led_bar_gauge_renderer_top.sv */
// Top level of the LED bar gauge renderer: config registers and block wiring.
`timescale 1ns / 1ps
`default_nettype none
// One input beat carries a reading and two button flags; a valid reading with a nonzero LED
// count yields one output beat per LED (at most 64) in strip order, tlast on the final one,
// while invalid readings only step the display mode. Readings pass through a two-entry
// queue to the renderer, which handles one reading at a time. For each gauge section the
// renderer, after setup, works out the fill percent and then the hue step, both on one
// shared bit-serial divider, then multiplies and emits one beat per LED while the output
// is taken. Configuration writes are accepted every cycle and must be made while idle.
module led_bar_gauge_renderer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // temperature, pressure, humidity, next_pressed,
                                        // previous_pressed
    input  wire logic        s_tuser,   // reading_valid
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // led_index, hue, saturation_on, brightness
    output logic [1:0]       m_tuser,   // shown_mode
    output logic             m_tlast,   // last_led
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    import lbg_pkg::*;

    lbg_cfg_t     cfg_reg;
    logic         q_push, q_full, q_pop, q_empty;
    lbg_item_t    q_wdata, q_rdata;
    lbg_div_req_t div_req;
    lbg_div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_count  <= CNT_W'(30);
            cfg_reg.temp_low   <= 15'sd2000;
            cfg_reg.temp_span  <= 14'd1500;
            cfg_reg.press_low  <= 17'd87000;
            cfg_reg.press_span <= 17'd21500;
            cfg_reg.hum_low    <= 14'd0;
            cfg_reg.hum_span   <= 14'd10000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lbg_reg_t'(cfg_index))
                REG_LED_COUNT:  cfg_reg.led_count  <= cfg_data[CNT_W-1:0];
                REG_TEMP_LOW:   cfg_reg.temp_low   <= cfg_data[14:0];
                REG_TEMP_SPAN:  cfg_reg.temp_span  <= cfg_data[13:0];
                REG_PRESS_LOW:  cfg_reg.press_low  <= cfg_data;
                REG_PRESS_SPAN: cfg_reg.press_span <= cfg_data;
                REG_HUM_LOW:    cfg_reg.hum_low    <= cfg_data[13:0];
                REG_HUM_SPAN:   cfg_reg.hum_span   <= cfg_data[13:0];
                default:        ;
            endcase
        end
    end

    lbg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .led_count (cfg_reg.led_count),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_wdata)
    );

    lbg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    lbg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lbg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .pop      (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
